// ===== sv/sva_pkg.sv =====
// Shared types and constants for the synthesizer voice allocator.
`default_nettype none
package sva_pkg;

  localparam int unsigned DEF_VOICES = 8;
  localparam int unsigned KEY_W      = 14;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned SEL_W      = 3;
  localparam int unsigned IDX_OUT_W  = 3;
  localparam int unsigned COUNT_W    = 4;

  localparam logic [STAMP_W-1:0] STAMP_NONE = '1;

  typedef enum logic [1:0] {
    OP_NOTE_ON    = 2'd0,
    OP_NOTE_OFF   = 2'd1,
    OP_ALL_OFF    = 2'd2,
    OP_VOICE_DONE = 2'd3
  } op_e;

  // One voice table entry. Whether the voice is busy at all is kept outside
  // the memory; rel tells release from playing for a busy voice.
  typedef struct packed {
    logic               rel;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } voice_rec_t;

endpackage
`default_nettype wire

// ===== sv/sva_voice_ram.sv =====
// Voice table memory: one write port, one registered read port.
`default_nettype none
module sva_voice_ram #(
  parameter int unsigned VOICES = sva_pkg::DEF_VOICES,
  parameter int unsigned IW     = 3
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [IW-1:0]      waddr_i,
  input  wire sva_pkg::voice_rec_t wdata_i,
  input  wire logic               re_i,
  input  wire logic [IW-1:0]      raddr_i,
  output sva_pkg::voice_rec_t     rdata_o
);
  import sva_pkg::*;

  voice_rec_t mem_q [VOICES];
  voice_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/sva_pick.sv =====
// Note-on voice selection, updated one table entry per cycle during a scan.
`default_nettype none
module sva_pick #(
  parameter int unsigned VOICES = sva_pkg::DEF_VOICES,
  parameter int unsigned IW     = 3
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clear_i,
  input  wire logic                     entry_vld_i,
  input  wire logic [IW-1:0]            entry_idx_i,
  input  wire logic                     entry_busy_i,
  input  wire sva_pkg::voice_rec_t      entry_i,
  input  wire logic [sva_pkg::KEY_W-1:0] key_i,
  output logic                          found_o,
  output logic [IW-1:0]                 idx_o
);
  import sva_pkg::*;

  logic               hit_vld_q, idle_vld_q, rel_vld_q, all_vld_q;
  logic [IW-1:0]      hit_idx_q, idle_idx_q, rel_idx_q, all_idx_q;
  logic [STAMP_W-1:0] rel_low_q, all_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_vld_q  <= 1'b0;
      idle_vld_q <= 1'b0;
      rel_vld_q  <= 1'b0;
      all_vld_q  <= 1'b0;
      hit_idx_q  <= '0;
      idle_idx_q <= '0;
      rel_idx_q  <= '0;
      all_idx_q  <= '0;
      rel_low_q  <= STAMP_NONE;
      all_low_q  <= STAMP_NONE;
    end else if (clear_i) begin
      hit_vld_q  <= 1'b0;
      idle_vld_q <= 1'b0;
      rel_vld_q  <= 1'b0;
      all_vld_q  <= 1'b0;
      rel_low_q  <= STAMP_NONE;
      all_low_q  <= STAMP_NONE;
    end else if (entry_vld_i) begin
      if (entry_busy_i) begin
        if (!hit_vld_q && entry_i.key == key_i) begin
          hit_vld_q <= 1'b1;
          hit_idx_q <= entry_idx_i;
        end
        // Strict compares keep the lowest index on ties and never take an
        // all-ones stamp.
        if (entry_i.rel && entry_i.stamp < rel_low_q) begin
          rel_vld_q <= 1'b1;
          rel_idx_q <= entry_idx_i;
          rel_low_q <= entry_i.stamp;
        end
        if (entry_i.stamp < all_low_q) begin
          all_vld_q <= 1'b1;
          all_idx_q <= entry_idx_i;
          all_low_q <= entry_i.stamp;
        end
      end else if (!idle_vld_q) begin
        idle_vld_q <= 1'b1;
        idle_idx_q <= entry_idx_i;
      end
    end
  end

  always_comb begin
    found_o = 1'b1;
    if (hit_vld_q) begin
      idx_o = hit_idx_q;
    end else if (idle_vld_q) begin
      idx_o = idle_idx_q;
    end else if (rel_vld_q) begin
      idx_o = rel_idx_q;
    end else begin
      idx_o   = all_idx_q;
      found_o = all_vld_q;
    end
  end

endmodule
`default_nettype wire

// ===== sv/synth_voice_allocator.sv =====
// Top level of the synthesizer voice allocator: sequencer, busy flags and counters.
`default_nettype none
// Usage:
//   An event (op_i, note_key_i, voice_sel_i) is taken at a rising edge with
//   start_i high and busy_o low. Each event gives exactly one result
//   transfer: voice_index_o, granted_o and active_count_o are valid for the
//   single cycle in which result_valid_o is high.
//   Note on, note off and all notes off walk the voice table in memory one
//   entry per cycle: reads for voices 0 to VOICES-1, then the read data of
//   the last voice, then the commit. busy_o drops in the same cycle in which
//   the result appears, and the next event can be taken at the edge that
//   ends that cycle. A voice-done event needs no walk: it goes straight to
//   the commit.
//   Writes back to the table during a walk always land on an entry already
//   read, so no forwarding is needed.
//   Reset marks every voice idle and clears the stamp counter and the busy
//   count; the table memory itself is not cleared, since a voice is only
//   looked at through its busy flag. The receiver cannot stall: a result
//   is shown once and is gone the next cycle, and a new event can be taken
//   in the cycle the result is shown.
module synth_voice_allocator #(
  parameter int unsigned VOICES = sva_pkg::DEF_VOICES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [sva_pkg::KEY_W-1:0]     note_key_i,
  input  wire logic [sva_pkg::SEL_W-1:0]     voice_sel_i,
  output logic                               result_valid_o,
  output logic [sva_pkg::IDX_OUT_W-1:0]      voice_index_o,
  output logic                               granted_o,
  output logic [sva_pkg::COUNT_W-1:0]        active_count_o
);
  import sva_pkg::*;

  localparam int unsigned IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW = $clog2(VOICES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(VOICES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e               state_q;
  op_e                  op_q;
  logic [KEY_W-1:0]     key_q;
  logic [SEL_W-1:0]     sel_q;
  logic [IW-1:0]        addr_q;
  logic                 issue_q;
  logic                 dv_q;
  logic [IW-1:0]        didx_q;
  logic [VOICES-1:0]    busy_q, busy_d;
  logic [CW-1:0]        count_q, count_d;
  logic [STAMP_W-1:0]   ctr_q, ctr_d;
  logic                 res_vld_q;
  logic [IDX_OUT_W-1:0] res_idx_q;
  logic                 res_grant_q;
  logic [COUNT_W-1:0]   res_count_q;

  logic                 rd_en;
  voice_rec_t           rdata;
  logic                 we;
  logic [IW-1:0]        waddr;
  voice_rec_t           wdata;
  logic                 pick_found;
  logic [IW-1:0]        pick_idx;
  logic                 grant;
  logic [IW-1:0]        gidx;
  logic [IW+SEL_W-1:0]  sel_ext;
  logic [IW-1:0]        sel_idx;
  logic                 sel_ok;
  logic [IW+IDX_OUT_W-1:0] gidx_ext;
  logic [CW+COUNT_W-1:0] count_ext;
  logic [COUNT_W-1:0]   count_sat;

  assign rd_en   = (state_q == ST_SCAN) && issue_q;
  assign sel_ext = {{IW{1'b0}}, sel_q};
  assign sel_idx = sel_ext[IW-1:0];
  assign sel_ok  = (int'(sel_q) < int'(VOICES));

  sva_voice_ram #(
    .VOICES (VOICES),
    .IW     (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  sva_pick #(
    .VOICES (VOICES),
    .IW     (IW)
  ) u_pick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      ((state_q == ST_IDLE) && start_i),
    .entry_vld_i  (dv_q && (op_q == OP_NOTE_ON)),
    .entry_idx_i  (didx_q),
    .entry_busy_i (busy_q[didx_q]),
    .entry_i      (rdata),
    .key_i        (key_q),
    .found_o      (pick_found),
    .idx_o        (pick_idx)
  );

  // Commit of the event and the table write port.
  always_comb begin
    busy_d  = busy_q;
    count_d = count_q;
    ctr_d   = ctr_q;
    grant   = 1'b0;
    gidx    = '0;
    we      = 1'b0;
    waddr   = didx_q;
    wdata   = rdata;
    case (state_q)
      ST_SCAN: begin
        // Note off releases matching playing voices; all off releases all.
        if (dv_q && busy_q[didx_q] && !rdata.rel) begin
          if ((op_q == OP_ALL_OFF) ||
              ((op_q == OP_NOTE_OFF) && (rdata.key == key_q))) begin
            we        = 1'b1;
            wdata.rel = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        case (op_q)
          OP_NOTE_ON: begin
            if (pick_found) begin
              grant = 1'b1;
              gidx  = pick_idx;
              if (!busy_q[pick_idx]) begin
                count_d = count_q + CW'(1);
              end
              busy_d[pick_idx] = 1'b1;
              ctr_d       = ctr_q + STAMP_W'(1);
              we          = 1'b1;
              waddr       = pick_idx;
              wdata.rel   = 1'b0;
              wdata.key   = key_q;
              wdata.stamp = ctr_q;
            end
          end
          OP_VOICE_DONE: begin
            if (sel_ok && busy_q[sel_idx]) begin
              busy_d[sel_idx] = 1'b0;
              count_d = count_q - CW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign gidx_ext  = {{IDX_OUT_W{1'b0}}, gidx};
  assign count_ext = {{COUNT_W{1'b0}}, count_d};
  assign count_sat = (count_ext > (CW + COUNT_W)'(15)) ? '1 : count_ext[COUNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NOTE_ON;
      key_q       <= '0;
      sel_q       <= '0;
      addr_q      <= '0;
      issue_q     <= 1'b0;
      dv_q        <= 1'b0;
      didx_q      <= '0;
      busy_q      <= '0;
      count_q     <= '0;
      ctr_q       <= '0;
      res_vld_q   <= 1'b0;
      res_idx_q   <= '0;
      res_grant_q <= 1'b0;
      res_count_q <= '0;
    end else begin
      res_vld_q <= 1'b0;
      dv_q      <= rd_en;
      didx_q    <= addr_q;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            op_q   <= op_e'(op_i);
            key_q  <= note_key_i;
            sel_q  <= voice_sel_i;
            addr_q <= '0;
            if (op_e'(op_i) == OP_VOICE_DONE) begin
              state_q <= ST_FINISH;
            end else begin
              issue_q <= 1'b1;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue_q) begin
            if (addr_q == LAST_IDX) begin
              issue_q <= 1'b0;
            end else begin
              addr_q <= addr_q + IW'(1);
            end
          end
          if (dv_q && (didx_q == LAST_IDX)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          busy_q      <= busy_d;
          count_q     <= count_d;
          ctr_q       <= ctr_d;
          res_vld_q   <= 1'b1;
          res_idx_q   <= gidx_ext[IDX_OUT_W-1:0];
          res_grant_q <= grant;
          res_count_q <= count_sat;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign voice_index_o  = res_idx_q;
  assign granted_o      = res_grant_q;
  assign active_count_o = res_count_q;

endmodule
`default_nettype wire

// ===== test/synth_voice_allocator_tb.sv =====
// Self-checking testbench for the synthesizer voice allocator.
`default_nettype none
module synth_voice_allocator_tb;
  import sva_pkg::*;

  localparam int unsigned VOICES      = DEF_VOICES;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          RAND_BLOCKS = 12;
  localparam int          BLOCK_LEN   = 50;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PLAY = 2'd1,
    ST_REL  = 2'd2
  } voice_stage_e;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] voice_index;
    logic                 granted;
    logic [COUNT_W-1:0]   active_count;
  } alloc_result_t;

  typedef struct {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [SEL_W-1:0] sel;
    bit               typed;
    alloc_result_t    res;
  } event_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic [1:0]           op_i        = 2'd0;
  logic [KEY_W-1:0]     note_key_i  = '0;
  logic [SEL_W-1:0]     voice_sel_i = '0;
  logic                 busy_o;
  logic                 result_valid_o;
  logic [IDX_OUT_W-1:0] voice_index_o;
  logic                 granted_o;
  logic [COUNT_W-1:0]   active_count_o;

  // Private copy of the voice table, updated at every accepted transfer.
  voice_stage_e       stage_tab [VOICES];
  logic [KEY_W-1:0]   key_tab   [VOICES];
  logic [STAMP_W-1:0] stamp_tab [VOICES];
  logic [STAMP_W-1:0] stamp_next;

  alloc_result_t alloc_results_due [$];

  int  failures      = 0;
  int  cycle_count   = 0;
  int  events_sent   = 0;
  int  results_seen  = 0;
  int  grants_seen   = 0;
  int  full_seen     = 0;
  bit  no_idle       = 1'b0;

  // Directed events. Rows with typed set carry a hand-derived result; the
  // stealing cases and most rows after them are left to the predictor.
  event_row_t script [24] = '{
    '{OP_NOTE_OFF,   14'd0,     3'd0, 1'b1, '{3'd0, 1'b0, 4'd0}},
    '{OP_ALL_OFF,    14'd0,     3'd0, 1'b1, '{3'd0, 1'b0, 4'd0}},
    '{OP_VOICE_DONE, 14'd0,     3'd7, 1'b1, '{3'd0, 1'b0, 4'd0}},
    '{OP_NOTE_ON,    14'd0,     3'd7, 1'b1, '{3'd0, 1'b1, 4'd1}},
    '{OP_NOTE_ON,    14'h3FFF,  3'd0, 1'b1, '{3'd1, 1'b1, 4'd2}},
    '{OP_NOTE_ON,    14'h3FFF,  3'd5, 1'b1, '{3'd1, 1'b1, 4'd2}},
    '{OP_NOTE_ON,    14'h1555,  3'd2, 1'b1, '{3'd2, 1'b1, 4'd3}},
    '{OP_NOTE_ON,    14'h2AAA,  3'd0, 1'b1, '{3'd3, 1'b1, 4'd4}},
    '{OP_NOTE_ON,    14'd100,   3'd0, 1'b1, '{3'd4, 1'b1, 4'd5}},
    '{OP_NOTE_ON,    14'd200,   3'd0, 1'b1, '{3'd5, 1'b1, 4'd6}},
    '{OP_NOTE_ON,    14'd300,   3'd0, 1'b1, '{3'd6, 1'b1, 4'd7}},
    '{OP_NOTE_ON,    14'd400,   3'd0, 1'b1, '{3'd7, 1'b1, 4'd8}},
    '{OP_NOTE_ON,    14'd500,   3'd0, 1'b0, '{3'd0, 1'b0, 4'd0}},
    '{OP_NOTE_OFF,   14'h3FFF,  3'd0, 1'b1, '{3'd0, 1'b0, 4'd8}},
    '{OP_NOTE_ON,    14'd600,   3'd0, 1'b0, '{3'd0, 1'b0, 4'd0}},
    '{OP_ALL_OFF,    14'd0,     3'd0, 1'b1, '{3'd0, 1'b0, 4'd8}},
    '{OP_NOTE_ON,    14'd700,   3'd0, 1'b0, '{3'd0, 1'b0, 4'd0}},
    '{OP_NOTE_OFF,   14'd200,   3'd0, 1'b0, '{3'd0, 1'b0, 4'd0}},
    '{OP_NOTE_ON,    14'd200,   3'd0, 1'b0, '{3'd0, 1'b0, 4'd0}},
    '{OP_VOICE_DONE, 14'd0,     3'd0, 1'b0, '{3'd0, 1'b0, 4'd0}},
    '{OP_VOICE_DONE, 14'h3FFF,  3'd0, 1'b0, '{3'd0, 1'b0, 4'd0}},
    '{OP_NOTE_ON,    14'h3FFF,  3'd0, 1'b0, '{3'd0, 1'b0, 4'd0}},
    '{OP_NOTE_OFF,   14'h3FFF,  3'd0, 1'b0, '{3'd0, 1'b0, 4'd0}},
    '{OP_VOICE_DONE, 14'd0,     3'd7, 1'b0, '{3'd0, 1'b0, 4'd0}}
  };

  synth_voice_allocator #(
    .VOICES(VOICES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .note_key_i    (note_key_i),
    .voice_sel_i   (voice_sel_i),
    .result_valid_o(result_valid_o),
    .voice_index_o (voice_index_o),
    .granted_o     (granted_o),
    .active_count_o(active_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Updates the table copy for one event and returns the result it causes.
  task automatic predict_allocation(input op_e op, input logic [KEY_W-1:0] key,
                                    input logic [SEL_W-1:0] sel,
                                    output alloc_result_t res);
    int                 pick;
    int                 busy;
    logic [STAMP_W-1:0] low;
    res  = '0;
    pick = -1;
    busy = 0;
    case (op)
      OP_NOTE_ON: begin
        for (int i = 0; i < VOICES; i++)
          if (pick < 0 && stage_tab[i] != ST_IDLE && key_tab[i] == key) pick = i;
        for (int i = 0; i < VOICES; i++)
          if (pick < 0 && stage_tab[i] == ST_IDLE) pick = i;
        if (pick < 0) begin
          low = STAMP_NONE;
          for (int i = 0; i < VOICES; i++)
            if (stage_tab[i] == ST_REL && stamp_tab[i] < low) begin
              low  = stamp_tab[i];
              pick = i;
            end
        end
        if (pick < 0) begin
          low = STAMP_NONE;
          for (int i = 0; i < VOICES; i++)
            if (stamp_tab[i] < low) begin
              low  = stamp_tab[i];
              pick = i;
            end
        end
        if (pick >= 0) begin
          stage_tab[pick] = ST_PLAY;
          key_tab[pick]   = key;
          stamp_tab[pick] = stamp_next;
          stamp_next      = stamp_next + 1'b1;
          res.voice_index = IDX_OUT_W'(pick);
          res.granted     = 1'b1;
        end
      end
      OP_NOTE_OFF: begin
        for (int i = 0; i < VOICES; i++)
          if (stage_tab[i] == ST_PLAY && key_tab[i] == key) stage_tab[i] = ST_REL;
      end
      OP_ALL_OFF: begin
        for (int i = 0; i < VOICES; i++)
          if (stage_tab[i] != ST_IDLE) stage_tab[i] = ST_REL;
      end
      default: begin
        if (sel < VOICES) stage_tab[sel] = ST_IDLE;
      end
    endcase
    for (int i = 0; i < VOICES; i++)
      if (stage_tab[i] != ST_IDLE) busy++;
    res.active_count = (busy > 15) ? 4'd15 : COUNT_W'(busy);
  endtask

  // Presents one event after a random gap and returns at the edge that
  // completes its transfer.
  task automatic send_event(input op_e op, input logic [KEY_W-1:0] key,
                            input logic [SEL_W-1:0] sel, input bit typed,
                            input alloc_result_t typed_res);
    int            gap;
    alloc_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    op_i        <= op;
    note_key_i  <= key;
    voice_sel_i <= sel;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_allocation(op, key, sel, predicted);
    alloc_results_due.push_back(typed ? typed_res : predicted);
    events_sent++;
  endtask

  always @(posedge clk_i) begin
    alloc_result_t due;
    if (result_valid_o) begin
      results_seen++;
      if (granted_o) grants_seen++;
      if (active_count_o == VOICES) full_seen++;
      if (alloc_results_due.size() == 0) begin
        $error("result transfer with nothing outstanding: voice_index %0d granted %0d count %0d",
               voice_index_o, granted_o, active_count_o);
        failures++;
      end else begin
        due = alloc_results_due.pop_front();
        if (voice_index_o !== due.voice_index) begin
          $error("voice_index: expected %0d, got %0d", due.voice_index, voice_index_o);
          failures++;
        end
        if (granted_o !== due.granted) begin
          $error("granted: expected %0d, got %0d", due.granted, granted_o);
          failures++;
        end
        if (active_count_o !== due.active_count) begin
          $error("active_count: expected %0d, got %0d", due.active_count, active_count_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("synth_voice_allocator verification failed");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] key_pool [16];
    logic [KEY_W-1:0] key;
    int               roll;
    int               on_lim;
    int               off_lim;
    int               all_lim;
    op_e              op;

    for (int i = 0; i < VOICES; i++) begin
      stage_tab[i] = ST_IDLE;
      key_tab[i]   = '0;
      stamp_tab[i] = '0;
    end
    stamp_next = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 16; i++) key_pool[i] = KEY_W'($urandom_range(0, 16383));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[r])
      send_event(script[r].op, script[r].key, script[r].sel, script[r].typed, script[r].res);

    // Keys mostly come from a small pool so that reuse, note off and stealing
    // all see matches; the op mix shifts from block to block.
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      no_idle = (blk % 3 == 1);
      case (blk % 4)
        0:       begin on_lim = 60; off_lim = 72; all_lim = 74; end
        2:       begin on_lim = 30; off_lim = 62; all_lim = 70; end
        default: begin on_lim = 40; off_lim = 62; all_lim = 66; end
      endcase
      for (int n = 0; n < BLOCK_LEN; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < on_lim)       op = OP_NOTE_ON;
        else if (roll < off_lim) op = OP_NOTE_OFF;
        else if (roll < all_lim) op = OP_ALL_OFF;
        else                     op = OP_VOICE_DONE;
        if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, 15)];
        else                            key = KEY_W'($urandom_range(0, 16383));
        send_event(op, key, SEL_W'($urandom_range(0, 7)), 1'b0, '0);
      end
    end

    start_i <= 1'b0;
    while (alloc_results_due.size() != 0) @(posedge clk_i);
    repeat (2 * VOICES + 6) @(posedge clk_i);

    $display("Sent %0d note events and checked %0d results.", events_sent, results_seen);
    $display("Voices granted %0d times; all %0d voices busy in %0d results.",
             grants_seen, VOICES, full_seen);
    if (failures == 0) begin
      $display("synth_voice_allocator verification clean");
    end else begin
      $display("synth_voice_allocator verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
